// ----- design/crc16p_pkg.sv -----
// ----------------------------------------------------------------------------
// crc16p_pkg
// Shared types, constants and helper functions of the framed command parser.
// ----------------------------------------------------------------------------
package crc16p_pkg;

  localparam int NumCfg   = 8;
  localparam int CfgIdxW  = $clog2(NumCfg);
  localparam int JqDepth  = 2;
  localparam int OqDepth  = 2;
  localparam int PlMax    = 4;
  localparam int MaxArgBytes = 4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  SofA      = 8'hAA;
  localparam logic [7:0]  SofB      = 8'h55;
  localparam logic [7:0]  ReplyAck  = 8'h80;
  localparam logic [7:0]  ReplyNack = 8'h81;
  localparam logic [7:0]  ErrCrc    = 8'h01;
  localparam logic [7:0]  ErrCmd    = 8'h03;
  localparam logic [7:0]  ErrArg    = 8'h05;

  typedef logic [NumCfg-1:0][7:0] cfg_t;

  localparam cfg_t CfgReset = {8'd19, 8'd18, 8'd17, 8'd16, 8'd4, 8'd3, 8'd2, 8'd1};

  typedef enum logic [3:0] {
    OP_PING    = 4'd0,
    OP_RESET   = 4'd1,
    OP_QUERY   = 4'd2,
    OP_ESTOP   = 4'd3,
    OP_GEAR    = 4'd4,
    OP_SERVO   = 4'd5,
    OP_CHASSIS = 4'd6,
    OP_PUSHROD = 4'd7,
    OP_NONE    = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    PH_SOF0,
    PH_SOF1,
    PH_HEAD,
    PH_ARG,
    PH_CRC0,
    PH_CRC1
  } phase_e;

  typedef enum logic [1:0] {
    JOB_EXEC,
    JOB_NACK_CMD,
    JOB_NACK_CRC
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  seq;
    logic [7:0]  cmd;
    logic [7:0]  arg;
  } job_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [1:0] gear;
    logic [1:0] servo;
    logic [1:0] pushrod;
    logic [6:0] speed;
    logic [5:0] trig;
  } out_t;

  // lowest register index wins on colliding codes
  function automatic op_e decode_cmd(cfg_t cfg, logic [7:0] cmd);
    op_e op;
    op = OP_NONE;
    for (int i = NumCfg - 1; i >= 0; i--) begin
      if (cfg[i] == cmd) op = op_e'(4'(i));
    end
    return op;
  endfunction

  function automatic logic [15:0] crc_add(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [6:0] gear_speed(logic [1:0] g);
    logic [6:0] s;
    unique case (g)
      2'd0:    s = 7'd0;
      2'd1:    s = 7'd70;
      2'd2:    s = 7'd85;
      default: s = 7'd100;
    endcase
    return s;
  endfunction

endpackage

// ----- design/crc16p_front.sv -----
// ----------------------------------------------------------------------------
// crc16p_front
// Receive side: sync hunt, header/argument capture, CRC check, job issue.
// ----------------------------------------------------------------------------
module crc16p_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  crc16p_pkg::cfg_t  cfg_i,
  output logic              job_we_o,
  output crc16p_pkg::job_t  job_o
);

  crc16p_pkg::phase_e phase_q, phase_d;
  logic        head_cnt_q, head_cnt_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  arg_q, arg_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_nxt;
  crc16p_pkg::op_e op;

  assign crc_nxt = crc16p_pkg::crc_add(crc_q, rx_byte_i);
  assign op      = crc16p_pkg::decode_cmd(cfg_i, rx_byte_i);

  always_comb begin
    phase_d    = phase_q;
    head_cnt_d = head_cnt_q;
    seq_d      = seq_q;
    cmd_d      = cmd_q;
    arg_d      = arg_q;
    crc_lo_d   = crc_lo_q;
    crc_d      = crc_q;
    job_we_o   = 1'b0;
    job_o.kind = crc16p_pkg::JOB_EXEC;
    job_o.seq  = seq_q;
    job_o.cmd  = cmd_q;
    job_o.arg  = arg_q;
    if (accept_i) begin
      unique case (phase_q)
        crc16p_pkg::PH_SOF0: begin
          if (rx_byte_i == crc16p_pkg::SofA) phase_d = crc16p_pkg::PH_SOF1;
        end
        crc16p_pkg::PH_SOF1: begin
          if (rx_byte_i == crc16p_pkg::SofB) begin
            head_cnt_d = 1'b0;
            crc_d      = crc16p_pkg::CrcInit;
            phase_d    = crc16p_pkg::PH_HEAD;
          end else if (rx_byte_i != crc16p_pkg::SofA) begin
            phase_d = crc16p_pkg::PH_SOF0;
          end
        end
        crc16p_pkg::PH_HEAD: begin
          crc_d = crc_nxt;
          if (!head_cnt_q) begin
            seq_d      = rx_byte_i;
            head_cnt_d = 1'b1;
          end else begin
            cmd_d = rx_byte_i;
            if (op == crc16p_pkg::OP_NONE) begin
              job_we_o   = 1'b1;
              job_o.kind = crc16p_pkg::JOB_NACK_CMD;
              job_o.cmd  = rx_byte_i;
              phase_d    = crc16p_pkg::PH_SOF0;
            end else if (op < crc16p_pkg::OP_GEAR) begin
              phase_d = crc16p_pkg::PH_CRC0;
            end else begin
              phase_d = crc16p_pkg::PH_ARG;
            end
          end
        end
        crc16p_pkg::PH_ARG: begin
          crc_d   = crc_nxt;
          arg_d   = rx_byte_i;
          phase_d = crc16p_pkg::PH_CRC0;
        end
        crc16p_pkg::PH_CRC0: begin
          crc_lo_d = rx_byte_i;
          phase_d  = crc16p_pkg::PH_CRC1;
        end
        crc16p_pkg::PH_CRC1: begin
          job_we_o   = 1'b1;
          job_o.kind = ({rx_byte_i, crc_lo_q} == crc_q) ? crc16p_pkg::JOB_EXEC
                                                       : crc16p_pkg::JOB_NACK_CRC;
          phase_d    = crc16p_pkg::PH_SOF0;
        end
        default: begin
          phase_d = crc16p_pkg::PH_SOF0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= crc16p_pkg::PH_SOF0;
      head_cnt_q <= 1'b0;
      crc_q      <= crc16p_pkg::CrcInit;
    end else begin
      phase_q    <= phase_d;
      head_cnt_q <= head_cnt_d;
      crc_q      <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q    <= seq_d;
    cmd_q    <= cmd_d;
    arg_q    <= arg_d;
    crc_lo_q <= crc_lo_d;
  end

endmodule

// ----- design/crc16p_jobq.sv -----
// ----------------------------------------------------------------------------
// crc16p_jobq
// Short queue of decoded frame jobs between the receive and execute sides.
// ----------------------------------------------------------------------------
module crc16p_jobq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  crc16p_pkg::job_t  job_i,
  input  logic              re_i,
  output crc16p_pkg::job_t  job_o,
  output logic              full_o,
  output logic              avail_o
);

  localparam int PtrW = $clog2(crc16p_pkg::JqDepth);
  localparam int CntW = $clog2(crc16p_pkg::JqDepth + 1);

  crc16p_pkg::job_t mem_q [crc16p_pkg::JqDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(crc16p_pkg::JqDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[wptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (we_i) wptr_q <= (wptr_q == PtrW'(crc16p_pkg::JqDepth - 1)) ? '0 : wptr_q + 1'b1;
      if (re_i) rptr_q <= (rptr_q == PtrW'(crc16p_pkg::JqDepth - 1)) ? '0 : rptr_q + 1'b1;
      if (we_i && !re_i)      cnt_q <= cnt_q + 1'b1;
      else if (!we_i && re_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- design/crc16p_back.sv -----
// ----------------------------------------------------------------------------
// crc16p_back
// Execute side: runs jobs, updates actuator state, streams reply frames.
// ----------------------------------------------------------------------------
module crc16p_back #(
  parameter int MaxArgBytes = crc16p_pkg::MaxArgBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crc16p_pkg::cfg_t  cfg_i,
  input  logic              job_avail_i,
  input  crc16p_pkg::job_t  job_i,
  output logic              job_re_o,
  input  logic              pop_i,
  output logic              empty_o,
  output crc16p_pkg::out_t  out_o
);

  localparam int OPtrW = $clog2(crc16p_pkg::OqDepth);
  localparam int OCntW = $clog2(crc16p_pkg::OqDepth + 1);

  logic        busy_q;
  logic [3:0]  idx_q;
  logic [7:0]  seq_q, rcmd_q;
  logic [7:0]  pl_q [crc16p_pkg::PlMax];
  logic [2:0]  plen_q;
  logic [15:0] crc_q;
  logic [1:0]  gear_q, servo_q, pushrod_q;
  logic [6:0]  speed_q;
  logic [5:0]  trig_q;

  crc16p_pkg::op_e op;
  logic [1:0]  ex_gear, ex_servo, ex_pushrod;
  logic [6:0]  ex_speed;
  logic [5:0]  ex_trig;
  logic [7:0]  ex_rcmd, ex_p1;
  logic [2:0]  ex_plen;
  logic        ex_status;

  logic        oq_full, emit, last, load, crc_upd, oq_re;
  logic [3:0]  pl_end;
  logic [7:0]  tx;
  crc16p_pkg::out_t oq_q [crc16p_pkg::OqDepth];
  crc16p_pkg::out_t owr;
  logic [OPtrW-1:0] owp_q, orp_q;
  logic [OCntW-1:0] ocnt_q;

  // job execution
  always_comb begin
    op         = crc16p_pkg::decode_cmd(cfg_i, job_i.cmd);
    ex_gear    = gear_q;
    ex_servo   = servo_q;
    ex_pushrod = pushrod_q;
    ex_speed   = speed_q;
    ex_trig    = trig_q;
    ex_rcmd    = crc16p_pkg::ReplyAck;
    ex_p1      = 8'h00;
    ex_plen    = 3'd2;
    ex_status  = 1'b0;
    unique case (job_i.kind)
      crc16p_pkg::JOB_NACK_CMD: begin
        ex_rcmd = crc16p_pkg::ReplyNack;
        ex_p1   = crc16p_pkg::ErrCmd;
      end
      crc16p_pkg::JOB_NACK_CRC: begin
        ex_rcmd = crc16p_pkg::ReplyNack;
        ex_p1   = crc16p_pkg::ErrCrc;
      end
      default: begin
        unique case (op)
          crc16p_pkg::OP_PING, crc16p_pkg::OP_RESET: begin
          end
          crc16p_pkg::OP_QUERY: begin
            ex_status = 1'b1;
            ex_rcmd   = cfg_i[crc16p_pkg::OP_QUERY];
            ex_plen   = 3'd4;
          end
          crc16p_pkg::OP_ESTOP: begin
            ex_servo   = 2'd0;
            ex_gear    = 2'd0;
            ex_speed   = crc16p_pkg::gear_speed(2'd0);
            ex_trig    = 6'h08;
            ex_pushrod = 2'd0;
          end
          crc16p_pkg::OP_GEAR: begin
            if (job_i.arg > 8'd3) begin
              ex_rcmd = crc16p_pkg::ReplyNack;
              ex_p1   = crc16p_pkg::ErrArg;
            end else begin
              ex_gear  = job_i.arg[1:0];
              ex_speed = crc16p_pkg::gear_speed(job_i.arg[1:0]);
            end
          end
          crc16p_pkg::OP_SERVO: begin
            if (job_i.arg > 8'd3) begin
              ex_rcmd = crc16p_pkg::ReplyNack;
              ex_p1   = crc16p_pkg::ErrArg;
            end else begin
              ex_servo = job_i.arg[1:0];
            end
          end
          crc16p_pkg::OP_CHASSIS: begin
            if (job_i.arg == 8'd4)      ex_trig = trig_q | 6'h01;
            else if (job_i.arg == 8'd1) ex_trig = trig_q | 6'h02;
            else if (job_i.arg == 8'd5) ex_trig = trig_q | 6'h04;
            else begin
              ex_rcmd = crc16p_pkg::ReplyNack;
              ex_p1   = crc16p_pkg::ErrArg;
            end
          end
          crc16p_pkg::OP_PUSHROD: begin
            if (job_i.arg > 8'd2) begin
              ex_rcmd = crc16p_pkg::ReplyNack;
              ex_p1   = crc16p_pkg::ErrArg;
            end else begin
              ex_trig    = trig_q | (6'h08 << job_i.arg[1:0]);
              ex_pushrod = job_i.arg[1:0];
            end
          end
          default: begin
            ex_rcmd = crc16p_pkg::ReplyNack;
            ex_p1   = crc16p_pkg::ErrCmd;
          end
        endcase
      end
    endcase
  end

  // reply byte sequencer
  assign pl_end  = 4'd4 + {1'b0, plen_q};
  assign oq_full = (ocnt_q == OCntW'(crc16p_pkg::OqDepth));
  assign emit    = busy_q && !oq_full;
  assign last    = (idx_q == pl_end + 4'd1);
  assign load    = job_avail_i && (!busy_q || (emit && last));
  assign crc_upd = (idx_q >= 4'd2) && (idx_q < pl_end);
  assign job_re_o = load;

  always_comb begin
    if (idx_q == 4'd0)       tx = crc16p_pkg::SofA;
    else if (idx_q == 4'd1)  tx = crc16p_pkg::SofB;
    else if (idx_q == 4'd2)  tx = seq_q;
    else if (idx_q == 4'd3)  tx = rcmd_q;
    else if (idx_q < pl_end) tx = pl_q[2'(idx_q - 4'd4)];
    else if (idx_q == pl_end) tx = crc_q[7:0];
    else                     tx = crc_q[15:8];
  end

  always_comb begin
    owr.tx_byte = tx;
    owr.tx_last = last;
    owr.gear    = gear_q;
    owr.servo   = servo_q;
    owr.pushrod = pushrod_q;
    owr.speed   = speed_q;
    owr.trig    = trig_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      crc_q     <= crc16p_pkg::CrcInit;
      gear_q    <= '0;
      servo_q   <= '0;
      pushrod_q <= '0;
      speed_q   <= '0;
      trig_q    <= '0;
    end else if (load) begin
      busy_q    <= (int'(ex_plen) <= MaxArgBytes);
      idx_q     <= '0;
      crc_q     <= crc16p_pkg::CrcInit;
      gear_q    <= ex_gear;
      servo_q   <= ex_servo;
      pushrod_q <= ex_pushrod;
      speed_q   <= ex_speed;
      trig_q    <= ex_trig;
    end else if (emit) begin
      if (last) busy_q <= 1'b0;
      idx_q <= idx_q + 4'd1;
      if (crc_upd) crc_q <= crc16p_pkg::crc_add(crc_q, tx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seq_q    <= job_i.seq;
      rcmd_q   <= ex_rcmd;
      plen_q   <= ex_plen;
      if (ex_status) begin
        pl_q[0] <= {6'd0, gear_q};
        pl_q[1] <= {6'd0, servo_q};
        pl_q[2] <= {6'd0, pushrod_q};
      end else begin
        pl_q[0] <= job_i.cmd;
        pl_q[1] <= ex_p1;
        pl_q[2] <= 8'h00;
      end
      pl_q[3] <= 8'h00;
    end
  end

  // result queue
  assign oq_re   = pop_i && (ocnt_q != '0);
  assign empty_o = (ocnt_q == '0);
  assign out_o   = oq_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (emit) oq_q[owp_q] <= owr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (emit)  owp_q <= (owp_q == OPtrW'(crc16p_pkg::OqDepth - 1)) ? '0 : owp_q + 1'b1;
      if (oq_re) orp_q <= (orp_q == OPtrW'(crc16p_pkg::OqDepth - 1)) ? '0 : orp_q + 1'b1;
      if (emit && !oq_re)      ocnt_q <= ocnt_q + 1'b1;
      else if (!emit && oq_re) ocnt_q <= ocnt_q - 1'b1;
    end
  end

endmodule

// ----- design/crc16_framed_command_parser.sv -----
// ----------------------------------------------------------------------------
// crc16_framed_command_parser
// Takes one received byte per cycle while the job queue is not full; a frame's
// final CRC byte leads to its reply, one byte per cycle while the result queue has room.
// Reply length is set by the back-end byte sequencer (8 or 10 bytes per frame).
// Reset is asynchronous: config returns to default codes, control state clears
// (data registers and queue storage keep their contents), no clearing pass.
// ----------------------------------------------------------------------------
module crc16_framed_command_parser #(
  parameter int MaxArgBytes = crc16p_pkg::MaxArgBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    rx_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    tx_byte_o,
  output logic                          tx_last_o,
  output logic [1:0]                    gear_now_o,
  output logic [1:0]                    servo_now_o,
  output logic [1:0]                    pushrod_now_o,
  output logic [6:0]                    throw_speed_o,
  output logic [5:0]                    trigger_lines_o,
  input  logic                          cfg_we_i,
  input  logic [crc16p_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_data_i
);

  crc16p_pkg::cfg_t cfg_q;
  crc16p_pkg::job_t job_in, job_out;
  crc16p_pkg::out_t res;
  logic job_we, job_re, jq_full, jq_avail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= crc16p_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign full = jq_full;

  crc16p_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (push && !jq_full),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .job_we_o  (job_we),
    .job_o     (job_in)
  );

  crc16p_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (job_we),
    .job_i   (job_in),
    .re_i    (job_re),
    .job_o   (job_out),
    .full_o  (jq_full),
    .avail_o (jq_avail)
  );

  crc16p_back #(
    .MaxArgBytes (MaxArgBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_avail_i (jq_avail),
    .job_i       (job_out),
    .job_re_o    (job_re),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_o       (res)
  );

  assign tx_byte_o       = res.tx_byte;
  assign tx_last_o       = res.tx_last;
  assign gear_now_o      = res.gear;
  assign servo_now_o     = res.servo;
  assign pushrod_now_o   = res.pushrod;
  assign throw_speed_o   = res.speed;
  assign trigger_lines_o = res.trig;

endmodule
